// ===== hdl/wli_pkg.sv =====
// Shared types and constants for the waypoint linear interpolator.
// Used by wli_front, wli_queue, wli_back and the top level; depends on nothing.
package wli_pkg;

  localparam int JOINTS_DEF        = 7;
  localparam int MAX_INTERVALS_DEF = 63;
  localparam int LANES             = 7;
  localparam int POS_W             = 32;
  localparam int CNT_W             = 6;
  localparam int DIFF_W            = POS_W + 1;
  localparam int ACC_W             = POS_W + 2;
  localparam int CFG_IDX_W         = 2;

  localparam logic [15:0] STEP_RESET = 16'd655;
  localparam logic [2:0]  JCNT_RESET = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JOINT_COUNT = 2'd1;

  // One segment handed from the front to the back.
  typedef struct packed {
    logic [LANES-1:0][POS_W-1:0] cur_pos;
    logic [POS_W-1:0]            cur_time;
    logic [LANES-1:0][POS_W-1:0] prev_pos;
    logic [POS_W-1:0]            prev_time;
    logic [CNT_W-1:0]            n;
    logic                        sat;
    logic                        fin;
  } seg_t;

  // One result point.
  typedef struct packed {
    logic [LANES-1:0][POS_W-1:0] pos;
    logic [POS_W-1:0]            ptime;
    logic                        last;
    logic                        sat;
  } point_t;

endpackage

// ===== hdl/waypoint_linear_interpolator.sv =====
// Waypoint linear interpolator top level: configuration registers and stream ports.
// Depends on wli_pkg, wli_front, wli_queue and wli_back.
//
// Each accepted waypoint passes through the front end, which scans every joint to find
// the largest change and then, once a previous waypoint is held, runs a six-step divide
// for the interval count n. The back end loads the segment, divides every joint change
// and the time change by n in parallel lanes, one quotient bit per cycle, sets up the
// stepping, and then emits one point per cycle while its output register is free, for
// n points, plus one more for a final waypoint. A two-entry queue lets the front end
// work on the following waypoints meanwhile. Points are held in an output register
// and flow at one per cycle while out_tready stays high.
module waypoint_linear_interpolator #(
  parameter int JOINTS        = wli_pkg::JOINTS_DEF,
  parameter int MAX_INTERVALS = wli_pkg::MAX_INTERVALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // joint_0_position .. joint_6_position, waypoint_time, 32 bits each
  input  logic [255:0]                      in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_joint_0 .. out_joint_6, point_time, 32 bits each
  output logic [255:0]                      out_tdata,
  output logic                              out_tlast,
  // count_saturated
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wli_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);

  logic [15:0]   step_r;
  logic [2:0]    jcnt_r;
  logic [2:0]    used;
  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  wli_pkg::seg_t fq_seg, qb_seg;
  wli_pkg::point_t point;
  logic [wli_pkg::LANES-1:0][wli_pkg::POS_W-1:0] in_pos;

  assign cfg_ready = 1'b1;
  assign used = (jcnt_r > 3'(JOINTS)) ? 3'(JOINTS) : jcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= wli_pkg::STEP_RESET;
      jcnt_r <= wli_pkg::JCNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wli_pkg::CFG_STEP_SIZE:   step_r <= cfg_data;
        wli_pkg::CFG_JOINT_COUNT: jcnt_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < wli_pkg::LANES; i++)
      in_pos[i] = in_tdata[i*wli_pkg::POS_W +: wli_pkg::POS_W];
  end

  wli_front #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pos    (in_pos),
    .in_time   (in_tdata[255:224]),
    .in_fin    (in_tlast),
    .step      (step_r),
    .used      (used),
    .seg_valid (fq_valid),
    .seg_ready (fq_ready),
    .seg       (fq_seg)
  );

  wli_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_seg),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_seg)
  );

  wli_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_valid (qb_valid),
    .seg_ready (qb_ready),
    .seg       (qb_seg),
    .used      (used),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_point (point)
  );

  assign out_tdata = {point.ptime, point.pos};
  assign out_tlast = point.last;
  assign out_tuser = point.sat;

endmodule

// ===== hdl/wli_front.sv =====
// Front end: accepts waypoints, finds the largest joint change and the interval count.
// Depends on wli_pkg; feeds segments to wli_queue.
module wli_front #(
  parameter int MAX_INTERVALS = wli_pkg::MAX_INTERVALS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [wli_pkg::LANES-1:0][wli_pkg::POS_W-1:0] in_pos,
  input  logic [wli_pkg::POS_W-1:0]                     in_time,
  input  logic                                          in_fin,
  input  logic [15:0]                                   step,
  input  logic [2:0]                                    used,
  output logic                                          seg_valid,
  input  logic                                          seg_ready,
  output wli_pkg::seg_t                                 seg
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MAX  = 5'b00010,
    F_PREP = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  localparam int X_W = wli_pkg::DIFF_W + 2;

  fstate_t                                        state_r, state_nxt;
  logic [wli_pkg::LANES-1:0][wli_pkg::POS_W-1:0]  cur_r, prev_r;
  logic [wli_pkg::POS_W-1:0]                      tcur_r, tprev_r;
  logic                                           fin_r, havep_r;
  logic [2:0]                                     j_r;
  logic [wli_pkg::DIFF_W-1:0]                     max_r;
  logic [X_W-1:0]                                 x_r;
  logic [2:0]                                     qbit_r;
  logic [wli_pkg::CNT_W-1:0]                      q_r, n_r;
  logic                                           sat_r;

  logic [15:0]                 s;
  logic [wli_pkg::DIFF_W-1:0]  diff, mag;
  logic [X_W-1:0]              dsh, dtop;
  logic                        ge;

  assign s    = (step == 16'd0) ? 16'd1 : step;
  assign diff = {cur_r[j_r][wli_pkg::POS_W-1], cur_r[j_r]}
              - {prev_r[j_r][wli_pkg::POS_W-1], prev_r[j_r]};
  assign mag  = diff[wli_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign dsh  = X_W'({s, 1'b0}) << qbit_r;
  assign dtop = X_W'({s, 7'b0});
  assign ge   = (x_r >= dsh);

  assign in_ready  = (state_r == F_IDLE);
  assign seg_valid = (state_r == F_PUSH);
  assign seg       = '{cur_pos: cur_r, cur_time: tcur_r, prev_pos: prev_r,
                       prev_time: tprev_r, n: n_r, sat: sat_r, fin: fin_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_MAX;
      F_MAX:  if (j_r == 3'(wli_pkg::LANES - 1)) state_nxt = havep_r ? F_PREP : F_PUSH;
      F_PREP: state_nxt = F_DIV;
      F_DIV:  if ((qbit_r == 3'd5 && x_r >= dtop) || qbit_r == 3'd0) state_nxt = F_PUSH;
      F_PUSH: if (seg_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      havep_r <= 1'b0;
      prev_r  <= '0;
      tprev_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            cur_r  <= in_pos;
            tcur_r <= in_time;
            fin_r  <= in_fin;
            j_r    <= 3'd0;
            max_r  <= '0;
            n_r    <= '0;
            sat_r  <= 1'b0;
          end
        end
        F_MAX: begin
          if (j_r < used && mag > max_r) max_r <= mag;
          j_r <= j_r + 3'd1;
        end
        F_PREP: begin
          // Round half up: n = (2*maxdiff + s) / (2*s).
          x_r    <= {max_r, 1'b0} + X_W'(s);
          qbit_r <= 3'd5;
          q_r    <= '0;
        end
        F_DIV: begin
          if (qbit_r == 3'd5 && x_r >= dtop) begin
            n_r   <= wli_pkg::CNT_W'(MAX_INTERVALS);
            sat_r <= 1'b1;
          end else begin
            if (ge) x_r <= x_r - dsh;
            q_r[qbit_r] <= ge;
            qbit_r <= qbit_r - 3'd1;
            if (qbit_r == 3'd0) begin
              if ({q_r[5:1], ge} > wli_pkg::CNT_W'(MAX_INTERVALS)) begin
                n_r   <= wli_pkg::CNT_W'(MAX_INTERVALS);
                sat_r <= 1'b1;
              end else begin
                n_r <= {q_r[5:1], ge};
              end
            end
          end
        end
        F_PUSH: begin
          if (seg_ready) begin
            prev_r  <= cur_r;
            tprev_r <= tcur_r;
            havep_r <= !fin_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/wli_queue.sv =====
// Two-entry segment queue between the front and the back.
// Depends on wli_pkg for the segment type.
module wli_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  wli_pkg::seg_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output wli_pkg::seg_t rd_data
);

  wli_pkg::seg_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/wli_back.sv =====
// Back end: divides each lane's change by n once, then steps the points out.
// Depends on wli_pkg; takes segments from wli_queue and drives the result register.
module wli_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 seg_valid,
  output logic                 seg_ready,
  input  wli_pkg::seg_t        seg,
  input  logic [2:0]           used,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wli_pkg::point_t      out_point
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_DIV   = 5'b00010,
    B_SETUP = 5'b00100,
    B_RUN   = 5'b01000,
    B_FINAL = 5'b10000
  } bstate_t;

  // Seven joint lanes and one time lane.
  localparam int NL = wli_pkg::LANES + 1;
  localparam int DW = wli_pkg::DIFF_W;
  localparam int AW = wli_pkg::ACC_W;
  localparam int CW = wli_pkg::CNT_W;
  localparam int PW = wli_pkg::POS_W;

  bstate_t                 state_r;
  wli_pkg::seg_t           seg_r;
  logic [NL-1:0]           neg_r;
  logic [NL-1:0][DW-1:0]   dvd_r, quo_r;
  logic [NL-1:0][CW-1:0]   rem_r, rd_r;
  logic [NL-1:0][AW-1:0]   qd_r, acc_r;
  logic [NL-1:0][CW:0]     racc_r;
  logic [5:0]              bit_r;
  logic [CW-1:0]           k_r;
  logic                    out_valid_r;
  wli_pkg::point_t         out_r;

  logic [NL-1:0][DW-1:0]   d;
  logic [NL-1:0][PW-1:0]   base;
  logic [NL-1:0][CW:0]     trial, rsum;
  logic [NL-1:0]           carry;
  logic [NL-1:0][PW-1:0]   val;
  logic                    slot_free;
  logic                    emit;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = slot_free && (state_r == B_RUN || state_r == B_FINAL);
  assign seg_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_point = out_r;

  always_comb begin
    for (int i = 0; i < wli_pkg::LANES; i++) begin
      d[i] = {seg.cur_pos[i][PW-1], seg.cur_pos[i]} - {seg.prev_pos[i][PW-1], seg.prev_pos[i]};
      base[i] = seg_r.prev_pos[i];
    end
    d[NL-1]    = {1'b0, seg.cur_time} - {1'b0, seg.prev_time};
    base[NL-1] = seg_r.prev_time;
    for (int i = 0; i < NL; i++) begin
      trial[i] = {rem_r[i], dvd_r[i][DW-1]};
      rsum[i]  = racc_r[i] + {1'b0, rd_r[i]};
      carry[i] = (rsum[i] >= {1'b0, seg_r.n});
      // Floor quotient plus one when the true quotient is negative and inexact.
      val[i]   = PW'({{(AW-PW){base[i][PW-1]}}, base[i]} + acc_r[i]
               + AW'(neg_r[i] && racc_r[i] != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (seg_valid) begin
            seg_r <= seg;
            bit_r <= '0;
            for (int i = 0; i < NL; i++) begin
              neg_r[i] <= d[i][DW-1];
              dvd_r[i] <= d[i][DW-1] ? (~d[i] + 1'b1) : d[i];
              rem_r[i] <= '0;
              quo_r[i] <= '0;
            end
            if (seg.n != '0)  state_r <= B_DIV;
            else if (seg.fin) state_r <= B_FINAL;
          end
        end
        B_DIV: begin
          for (int i = 0; i < NL; i++) begin
            dvd_r[i] <= dvd_r[i] << 1;
            if (trial[i] >= {1'b0, seg_r.n}) begin
              rem_r[i] <= CW'(trial[i] - {1'b0, seg_r.n});
              quo_r[i] <= {quo_r[i][DW-2:0], 1'b1};
            end else begin
              rem_r[i] <= trial[i][CW-1:0];
              quo_r[i] <= {quo_r[i][DW-2:0], 1'b0};
            end
          end
          bit_r <= bit_r + 6'd1;
          if (bit_r == 6'(DW - 1)) state_r <= B_SETUP;
        end
        B_SETUP: begin
          for (int i = 0; i < NL; i++) begin
            if (!neg_r[i]) begin
              qd_r[i] <= AW'(quo_r[i]);
              rd_r[i] <= rem_r[i];
            end else if (rem_r[i] == '0) begin
              qd_r[i] <= -AW'(quo_r[i]);
              rd_r[i] <= '0;
            end else begin
              qd_r[i] <= -AW'(quo_r[i]) - AW'(1);
              rd_r[i] <= seg_r.n - rem_r[i];
            end
            acc_r[i]  <= '0;
            racc_r[i] <= '0;
          end
          k_r     <= '0;
          state_r <= B_RUN;
        end
        B_RUN: begin
          if (slot_free) begin
            for (int i = 0; i < wli_pkg::LANES; i++)
              out_r.pos[i] <= (3'(i) < used) ? val[i] : '0;
            out_r.ptime <= val[NL-1];
            out_r.last  <= 1'b0;
            out_r.sat   <= seg_r.sat;
            for (int i = 0; i < NL; i++) begin
              acc_r[i]  <= acc_r[i] + qd_r[i] + AW'(carry[i]);
              racc_r[i] <= carry[i] ? (rsum[i] - {1'b0, seg_r.n}) : rsum[i];
            end
            k_r <= k_r + 1'b1;
            if (k_r == seg_r.n - 1'b1) state_r <= seg_r.fin ? B_FINAL : B_IDLE;
          end
        end
        B_FINAL: begin
          if (slot_free) begin
            for (int i = 0; i < wli_pkg::LANES; i++)
              out_r.pos[i] <= (3'(i) < used) ? seg_r.cur_pos[i] : '0;
            out_r.ptime <= seg_r.cur_time;
            out_r.last  <= 1'b1;
            out_r.sat   <= seg_r.sat;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
